// ===== src/wets_pkg.sv =====
// Package for the weighted edge table selector.
// Holds payload structs, opcode and status codes, engine state types.
// No dependencies.
package wets_pkg;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_ENH = 3'd1,
      OP_DEL = 3'd2,
      OP_AGE = 3'd3,
      OP_SEL = 3'd4,
      OP_SUM = 3'd5
   } op_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_PRESENT   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NONE      = 3'd4;

   localparam logic CSR_AGING  = 1'b0;
   localparam logic CSR_THRESH = 1'b1;

   localparam logic [16:0] AGING_RESET = 17'h10000;
   localparam logic [37:0] SUM_MAX     = 38'h3F_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] neighbor_id;
      logic [31:0] amount;
      logic [15:0] random_fraction;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] chosen_id;
      logic [31:0] chosen_weight;
      logic [37:0] total_wt;
   } rsp_payload_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] id;
      logic [31:0] amount;
      logic [15:0] frac;
   } job_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FIN,
      S_LAST_RD,
      S_LAST_WR,
      S_MUL,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_LOOKUP,
      PH_AGE,
      PH_TOTAL,
      PH_PICK,
      PH_SUM
   } phase_type;

endpackage

// ===== src/weighted_edge_table_selector.sv =====
// Top level of the weighted edge table selector: config registers,
// front queue and back-end engine. Depends on wets_pkg, wets_front, wets_engine.
//
//   port group   direction   handshake
//   req_*        in          req_valid / req_stall
//   rsp_*        out         rsp_valid / rsp_stall
//   csr_*        in          csr_we, no wait
//
// Sum is one pass; add and enhance look up, then re-sum; delete also moves the last
// entry into the hole; age ages, then re-sums; select totals, scales, picks, re-sums.
// Every pass reads one entry per cycle through the table memory's single read port.
// Reset empties the table at once; no clearing pass.
// A stalled result holds in the output register while the engine runs one more job
// and the front queue takes up to two more requests.
module weighted_edge_table_selector #(
   parameter int TABLE_DEPTH = 64,
   parameter int ID_BITS     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  wets_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output wets_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [31:0]               csr_wdata
);

   logic [16:0] aging_ff, aging_in;
   logic [31:0] thresh_ff, thresh_in;
   logic        deq_valid;
   logic        deq_ready;
   wets_pkg::job_type deq_job;

   always_comb begin
      aging_in  = aging_ff;
      thresh_in = thresh_ff;
      if (csr_we) begin
         case (csr_index)
            wets_pkg::CSR_AGING:  aging_in  = csr_wdata[16:0];
            wets_pkg::CSR_THRESH: thresh_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aging_ff  <= wets_pkg::AGING_RESET;
         thresh_ff <= '0;
      end else begin
         aging_ff  <= aging_in;
         thresh_ff <= thresh_in;
      end
   end

   wets_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .deq_valid   (deq_valid),
      .deq_ready   (deq_ready),
      .deq_job     (deq_job)
   );

   wets_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .deq_valid      (deq_valid),
      .deq_ready      (deq_ready),
      .deq_job        (deq_job),
      .age_mult       (aging_ff),
      .drop_threshold (thresh_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

endmodule

// ===== src/wets_front.sv =====
// Front end: accepts requests, decodes the command and queues jobs.
// Two-entry queue toward the engine. Depends on wets_pkg.
module wets_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  wets_pkg::req_payload_type req_payload,
   output logic                     deq_valid,
   input  logic                     deq_ready,
   output wets_pkg::job_type        deq_job
);

   wets_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   wets_pkg::job_type job;

   always_comb begin
      job.id     = req_payload.neighbor_id;
      job.amount = req_payload.amount;
      job.frac   = req_payload.random_fraction;
      case (req_payload.command)
         wets_pkg::OP_ADD: job.op = wets_pkg::OP_ADD;
         wets_pkg::OP_ENH: job.op = wets_pkg::OP_ENH;
         wets_pkg::OP_DEL: job.op = wets_pkg::OP_DEL;
         wets_pkg::OP_AGE: job.op = wets_pkg::OP_AGE;
         wets_pkg::OP_SEL: job.op = wets_pkg::OP_SEL;
         default:          job.op = wets_pkg::OP_SUM;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign deq_valid = (cnt_ff != 2'd0);
   assign pop       = deq_valid && deq_ready;
   assign deq_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= job;
      end
   end

endmodule

// ===== src/wets_engine.sv =====
// Back end: table memory, scan sequencer, aging multiplier and result register.
// Runs one job at a time. Depends on wets_pkg.
module wets_engine #(
   parameter int TABLE_DEPTH = 64,
   parameter int ID_BITS     = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      deq_valid,
   output logic                      deq_ready,
   input  wets_pkg::job_type         deq_job,
   input  logic [16:0]               age_mult,
   input  logic [31:0]               drop_threshold,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output wets_pkg::rsp_payload_type rsp_payload
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int RW = 32 + AW;
   localparam int SW = (RW > 38) ? RW : 38;

   logic [ID_BITS-1:0] id_mem [TABLE_DEPTH];
   logic [31:0]        w_mem  [TABLE_DEPTH];

   logic [ID_BITS-1:0] d_id_ff;
   logic [31:0]        d_w_ff;

   wets_pkg::state_type state_ff, state_in;
   wets_pkg::phase_type phase_ff, phase_in;
   wets_pkg::job_type   cur_ff, cur_in;

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic [CW-1:0]      k_ff, k_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic               hit_ff, hit_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [31:0]        wgt_ff, wgt_in;
   logic [SW-1:0]      acc_ff, acc_in;
   logic [SW-1:0]      r_ff, r_in;
   logic               prod_vld_ff, prod_vld_in;
   logic [32:0]        prod_ff, prod_in;
   logic [ID_BITS-1:0] prod_id_ff, prod_id_in;
   logic [2:0]         status_ff, status_in;
   logic [ID_BITS-1:0] cid_ff, cid_in;
   logic [31:0]        cw_ff, cw_in;
   logic               rsp_valid_ff, rsp_valid_in;
   wets_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ID_BITS-1:0] wr_id;
   logic [31:0]        wr_w;

   logic [ID_BITS-1:0] cur_id;
   logic               issue_go;
   logic               scan_done;
   logic [48:0]        age_prod;
   logic [SW+15:0]     r_prod;
   logic [SW-1:0]      run_sum;
   logic [32:0]        enh_sum;
   logic [31:0]        aged_w;
   logic [37:0]        sum_sat;

   assign cur_id    = ID_BITS'(cur_ff.id);
   assign issue_go  = (state_ff == wets_pkg::S_SCAN) && (issue_ff < count_ff) && !hit_ff;
   assign scan_done = (!issue_go) && !rd_vld_ff && !prod_vld_ff;
   assign age_prod  = 49'(d_w_ff) * 49'(age_mult);
   assign r_prod    = (SW + 16)'(acc_ff) * (SW + 16)'(cur_ff.frac);
   assign run_sum   = acc_ff + ((d_id_ff != cur_id) ? SW'(d_w_ff) : SW'(0));
   assign enh_sum   = {1'b0, wgt_ff} + {1'b0, cur_ff.amount};
   assign aged_w    = prod_ff[32] ? 32'hFFFF_FFFF : prod_ff[31:0];
   assign sum_sat   = (acc_ff > SW'(wets_pkg::SUM_MAX)) ? wets_pkg::SUM_MAX : acc_ff[37:0];
   assign deq_ready = (state_ff == wets_pkg::S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      cur_in         = cur_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      k_in           = k_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      hit_in         = hit_ff;
      pos_in         = pos_ff;
      wgt_in         = wgt_ff;
      acc_in         = acc_ff;
      r_in           = r_ff;
      prod_vld_in    = 1'b0;
      prod_in        = prod_ff;
      prod_id_in     = prod_id_ff;
      status_in      = status_ff;
      cid_in         = cid_ff;
      cw_in          = cw_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      rd_en          = 1'b0;
      rd_addr        = issue_ff[AW-1:0];
      wr_en          = 1'b0;
      wr_addr        = k_ff[AW-1:0];
      wr_id          = prod_id_ff;
      wr_w           = aged_w;

      // issue reads
      if (issue_go) begin
         rd_en     = 1'b1;
         rd_vld_in = 1'b1;
         rd_idx_in = issue_ff[AW-1:0];
         issue_in  = issue_ff + CW'(1);
      end

      // consume read data
      if (rd_vld_ff) begin
         case (phase_ff)
            wets_pkg::PH_LOOKUP: begin
               if (!hit_ff && d_id_ff == cur_id) begin
                  hit_in = 1'b1;
                  pos_in = rd_idx_ff;
                  wgt_in = d_w_ff;
               end
            end
            wets_pkg::PH_AGE: begin
               prod_vld_in = 1'b1;
               prod_in     = age_prod[48:16];
               prod_id_in  = d_id_ff;
            end
            wets_pkg::PH_TOTAL: begin
               if (d_id_ff != cur_id) begin
                  acc_in = acc_ff + SW'(d_w_ff);
               end
            end
            wets_pkg::PH_PICK: begin
               if (!hit_ff) begin
                  acc_in = run_sum;
                  if (run_sum > r_ff) begin
                     hit_in = 1'b1;
                     cid_in = d_id_ff;
                     cw_in  = d_w_ff;
                  end
               end
            end
            wets_pkg::PH_SUM: begin
               acc_in = acc_ff + SW'(d_w_ff);
            end
            default: begin
            end
         endcase
      end

      // compact aged entries
      if (prod_vld_ff && aged_w >= drop_threshold) begin
         wr_en = 1'b1;
         k_in  = k_ff + CW'(1);
      end

      case (state_ff)
         wets_pkg::S_IDLE: begin
            if (deq_valid) begin
               cur_in    = deq_job;
               status_in = wets_pkg::ST_OK;
               cid_in    = '0;
               cw_in     = '0;
               issue_in  = '0;
               hit_in    = 1'b0;
               acc_in    = '0;
               k_in      = '0;
               state_in  = wets_pkg::S_SCAN;
               case (deq_job.op)
                  wets_pkg::OP_AGE: phase_in = wets_pkg::PH_AGE;
                  wets_pkg::OP_SEL: phase_in = wets_pkg::PH_TOTAL;
                  wets_pkg::OP_SUM: phase_in = wets_pkg::PH_SUM;
                  default:          phase_in = wets_pkg::PH_LOOKUP;
               endcase
            end
         end
         wets_pkg::S_SCAN: begin
            if (scan_done) begin
               state_in = wets_pkg::S_FIN;
            end
         end
         wets_pkg::S_FIN: begin
            issue_in = '0;
            hit_in   = 1'b0;
            acc_in   = '0;
            k_in     = '0;
            phase_in = wets_pkg::PH_SUM;
            state_in = wets_pkg::S_SCAN;
            case (phase_ff)
               wets_pkg::PH_LOOKUP: begin
                  case (cur_ff.op)
                     wets_pkg::OP_ADD: begin
                        if (hit_ff) begin
                           status_in = wets_pkg::ST_PRESENT;
                        end else if (count_ff == CW'(TABLE_DEPTH)) begin
                           status_in = wets_pkg::ST_FULL;
                        end else begin
                           wr_en    = 1'b1;
                           wr_addr  = count_ff[AW-1:0];
                           wr_id    = cur_id;
                           wr_w     = cur_ff.amount;
                           count_in = count_ff + CW'(1);
                        end
                     end
                     wets_pkg::OP_ENH: begin
                        if (hit_ff) begin
                           wr_en   = 1'b1;
                           wr_addr = pos_ff;
                           wr_id   = cur_id;
                           wr_w    = enh_sum[32] ? 32'hFFFF_FFFF : enh_sum[31:0];
                        end else begin
                           status_in = wets_pkg::ST_NOT_FOUND;
                        end
                     end
                     default: begin
                        if (hit_ff) begin
                           count_in = count_ff - CW'(1);
                           state_in = wets_pkg::S_LAST_RD;
                        end else begin
                           status_in = wets_pkg::ST_NOT_FOUND;
                        end
                     end
                  endcase
               end
               wets_pkg::PH_AGE: begin
                  count_in = k_ff;
               end
               wets_pkg::PH_TOTAL: begin
                  if (acc_ff == '0) begin
                     status_in = wets_pkg::ST_NONE;
                  end else begin
                     acc_in   = acc_ff;
                     state_in = wets_pkg::S_MUL;
                  end
               end
               wets_pkg::PH_SUM: begin
                  acc_in   = acc_ff;
                  state_in = wets_pkg::S_DONE;
               end
               default: begin
               end
            endcase
         end
         wets_pkg::S_LAST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = count_ff[AW-1:0];
            state_in = wets_pkg::S_LAST_WR;
         end
         wets_pkg::S_LAST_WR: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_id    = d_id_ff;
            wr_w     = d_w_ff;
            issue_in = '0;
            hit_in   = 1'b0;
            acc_in   = '0;
            phase_in = wets_pkg::PH_SUM;
            state_in = wets_pkg::S_SCAN;
         end
         wets_pkg::S_MUL: begin
            r_in     = SW'(r_prod >> 16);
            issue_in = '0;
            hit_in   = 1'b0;
            acc_in   = '0;
            phase_in = wets_pkg::PH_PICK;
            state_in = wets_pkg::S_SCAN;
         end
         wets_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.status        = status_ff;
               rsp_payload_in.chosen_id     = 16'(cid_ff);
               rsp_payload_in.chosen_weight = cw_ff;
               rsp_payload_in.total_wt      = sum_sat;
               state_in                     = wets_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wets_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wets_pkg::S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff       <= phase_in;
      cur_ff         <= cur_in;
      issue_ff       <= issue_in;
      k_ff           <= k_in;
      rd_idx_ff      <= rd_idx_in;
      hit_ff         <= hit_in;
      pos_ff         <= pos_in;
      wgt_ff         <= wgt_in;
      acc_ff         <= acc_in;
      r_ff           <= r_in;
      prod_ff        <= prod_in;
      prod_id_ff     <= prod_id_in;
      status_ff      <= status_in;
      cid_ff         <= cid_in;
      cw_ff          <= cw_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr] <= wr_id;
         w_mem[wr_addr]  <= wr_w;
      end
      if (rd_en) begin
         d_id_ff <= id_mem[rd_addr];
         d_w_ff  <= w_mem[rd_addr];
      end
   end

endmodule

// ===== tb/weighted_edge_table_selector_tb.sv =====
// Testbench for the weighted edge table selector: a directed request table, a table
// fill, aging runs and random traffic, all checked against a behavioral table model.
// Depends on wets_pkg and the weighted_edge_table_selector RTL.
`timescale 1ns / 1ps

module weighted_edge_table_selector_tb;

   localparam int DEPTH = 64;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   wets_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   wets_pkg::rsp_payload_type rsp_payload;
   logic                      csr_we = 1'b0;
   logic                      csr_index = 1'b0;
   logic [31:0]               csr_wdata = '0;

   weighted_edge_table_selector dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   logic [15:0]               tbl_id [DEPTH];
   logic [31:0]               tbl_wt [DEPTH];
   int                        tbl_count;
   logic [16:0]               aging;
   logic [31:0]               thresh;
   wets_pkg::rsp_payload_type expected_rsps[$];
   int                        mismatches = 0;
   int                        accepted_rsps = 0;
   int                        sent_reqs = 0;
   int                        selects_made = 0;
   int                        rsp_wait = 0;

   function automatic int find_id(logic [15:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic wets_pkg::rsp_payload_type apply_command(wets_pkg::req_payload_type rq);
      wets_pkg::rsp_payload_type r;
      int              pos;
      int              k;
      logic [48:0]     prod;
      logic [31:0]     nw;
      logic [37:0]     tot;
      logic [37:0]     pick;
      logic [37:0]     run;
      logic [53:0]     scaled;
      r = '0;
      r.status = wets_pkg::ST_OK;
      case (rq.command)
         wets_pkg::OP_ADD: begin
            if (find_id(rq.neighbor_id) >= 0) r.status = wets_pkg::ST_PRESENT;
            else if (tbl_count >= DEPTH) r.status = wets_pkg::ST_FULL;
            else begin
               tbl_id[tbl_count] = rq.neighbor_id;
               tbl_wt[tbl_count] = rq.amount;
               tbl_count++;
            end
         end
         wets_pkg::OP_ENH: begin
            pos = find_id(rq.neighbor_id);
            if (pos < 0) r.status = wets_pkg::ST_NOT_FOUND;
            else if ({1'b0, tbl_wt[pos]} + {1'b0, rq.amount} > 33'hFFFF_FFFF)
               tbl_wt[pos] = 32'hFFFF_FFFF;
            else tbl_wt[pos] = tbl_wt[pos] + rq.amount;
         end
         wets_pkg::OP_DEL: begin
            pos = find_id(rq.neighbor_id);
            if (pos < 0) r.status = wets_pkg::ST_NOT_FOUND;
            else begin
               tbl_count--;
               tbl_id[pos] = tbl_id[tbl_count];
               tbl_wt[pos] = tbl_wt[tbl_count];
            end
         end
         wets_pkg::OP_AGE: begin
            k = 0;
            for (int i = 0; i < tbl_count; i++) begin
               prod = (49'(tbl_wt[i]) * 49'(aging)) >> 16;
               nw = (prod > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
               if (nw >= thresh) begin
                  tbl_id[k] = tbl_id[i];
                  tbl_wt[k] = nw;
                  k++;
               end
            end
            tbl_count = k;
         end
         wets_pkg::OP_SEL: begin
            tot = '0;
            for (int i = 0; i < tbl_count; i++)
               if (tbl_id[i] != rq.neighbor_id) tot += tbl_wt[i];
            if (tot == 0) r.status = wets_pkg::ST_NONE;
            else begin
               scaled = 54'(tot) * 54'(rq.random_fraction);
               pick = scaled[53:16];
               run = '0;
               for (int i = 0; i < tbl_count; i++) begin
                  if (tbl_id[i] != rq.neighbor_id) run += tbl_wt[i];
                  if (run > pick) begin
                     r.chosen_id = tbl_id[i];
                     r.chosen_weight = tbl_wt[i];
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      tot = '0;
      for (int i = 0; i < tbl_count; i++) tot += tbl_wt[i];
      r.total_wt = tot;
      return r;
   endfunction

   task automatic write_csr(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == wets_pkg::CSR_AGING) aging = val[16:0];
      else thresh = val;
   endtask

   task automatic send_request(wets_pkg::req_payload_type rq);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.insert(expected_rsps.size(), apply_command(rq));
      if (rq.command == wets_pkg::OP_SEL) selects_made++;
      sent_reqs++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   function automatic wets_pkg::req_payload_type mk(logic [2:0] c, logic [15:0] id,
                                                    logic [31:0] a, logic [15:0] f);
      wets_pkg::req_payload_type rq;
      rq.command = c; rq.neighbor_id = id; rq.amount = a; rq.random_fraction = f;
      return rq;
   endfunction

   function automatic wets_pkg::req_payload_type random_request();
      logic [15:0] id;
      logic [2:0]  c;
      int          w;
      id = (tbl_count > 0 && $urandom_range(0, 2) != 0) ?
           tbl_id[$urandom_range(0, tbl_count - 1)] : 16'($urandom_range(0, 40));
      if ($urandom_range(0, 15) == 0) id = 16'($urandom);
      w = $urandom_range(0, 99);
      if (w < 30) c = wets_pkg::OP_ADD;
      else if (w < 45) c = wets_pkg::OP_ENH;
      else if (w < 57) c = wets_pkg::OP_DEL;
      else if (w < 62) c = wets_pkg::OP_AGE;
      else if (w < 92) c = wets_pkg::OP_SEL;
      else if (w < 96) c = wets_pkg::OP_SUM;
      else c = 3'($urandom_range(6, 7));
      return mk(c, id, ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h3_0000),
                16'($urandom));
   endfunction

   // directed requests: command, id, amount, fraction, known status or 7 for predictor
   typedef struct {
      logic [2:0]  c;
      logic [15:0] id;
      logic [31:0] a;
      logic [15:0] f;
      logic [2:0]  st;
   } dir_row_type;

   dir_row_type dir_rows[] = '{
      '{wets_pkg::OP_SUM, 16'd0,    32'd0,         16'd0,    wets_pkg::ST_OK},
      '{wets_pkg::OP_SEL, 16'd0,    32'd0,         16'hFFFF, wets_pkg::ST_NONE},
      '{wets_pkg::OP_ENH, 16'd5,    32'd1,         16'd0,    wets_pkg::ST_NOT_FOUND},
      '{wets_pkg::OP_DEL, 16'd5,    32'd0,         16'd0,    wets_pkg::ST_NOT_FOUND},
      '{wets_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 16'd0,    wets_pkg::ST_OK},
      '{wets_pkg::OP_ADD, 16'hFFFF, 32'd1,         16'd0,    wets_pkg::ST_PRESENT},
      '{wets_pkg::OP_ADD, 16'd0,    32'd0,         16'd0,    wets_pkg::ST_OK},
      '{wets_pkg::OP_ADD, 16'h5A5A, 32'h0001_0000, 16'd0,    wets_pkg::ST_OK},
      '{wets_pkg::OP_ENH, 16'hFFFF, 32'hFFFF_FFFF, 16'd0,    wets_pkg::ST_OK},
      '{wets_pkg::OP_ENH, 16'h5A5A, 32'h8000_0000, 16'd0,    wets_pkg::ST_OK},
      '{wets_pkg::OP_SEL, 16'hFFFF, 32'd0,         16'd0,    3'd7},
      '{wets_pkg::OP_SEL, 16'd1,    32'd0,         16'hFFFF, 3'd7},
      '{wets_pkg::OP_SEL, 16'd1,    32'd0,         16'h0000, 3'd7},
      '{wets_pkg::OP_SEL, 16'h5A5A, 32'd0,         16'h8000, 3'd7},
      '{3'd6,             16'd0,    32'd0,         16'd0,    wets_pkg::ST_OK},
      '{3'd7,             16'hA5A5, 32'h5555_5555, 16'hAAAA, wets_pkg::ST_OK},
      '{wets_pkg::OP_AGE, 16'd0,    32'd0,         16'd0,    wets_pkg::ST_OK},
      '{wets_pkg::OP_DEL, 16'hFFFF, 32'd0,         16'd0,    wets_pkg::ST_OK},
      '{wets_pkg::OP_DEL, 16'd0,    32'd0,         16'd0,    wets_pkg::ST_OK},
      '{wets_pkg::OP_SEL, 16'hFFFF, 32'd0,         16'h1234, 3'd7}
   };

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         else if (rsp_valid && rsp_wait > 0)
            rsp_wait--;
         rsp_stall <= (rsp_wait > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         accepted_rsps++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_payload);
         end else begin
            wets_pkg::rsp_payload_type e;
            e = expected_rsps.pop_front();
            if (rsp_payload !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected %p, got %p", accepted_rsps, e, rsp_payload);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("weighted_edge_table_selector: mismatch");
      $finish;
   end

   initial begin
      tbl_count = 0;
      aging = wets_pkg::AGING_RESET;
      thresh = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         send_request(mk(dir_rows[i].c, dir_rows[i].id, dir_rows[i].a, dir_rows[i].f));
         if (dir_rows[i].st != 3'd7 && expected_rsps[$].status != dir_rows[i].st) begin
            mismatches++;
            $display("directed row %0d: table status %0d, model %0d",
                     i, dir_rows[i].st, expected_rsps[$].status);
         end
      end
      // fill the table to the full case
      for (int i = 0; i < DEPTH + 2; i++)
         send_request(mk(wets_pkg::OP_ADD, 16'(1000 + i),
                         32'($urandom_range(0, 32'h2_0000)), 16'd0));
      drain();
      write_csr(wets_pkg::CSR_AGING, 32'h0_8000);
      write_csr(wets_pkg::CSR_THRESH, 32'h0000_4000);
      send_request(mk(wets_pkg::OP_AGE, 16'd0, 32'd0, 16'd0));
      drain();
      write_csr(wets_pkg::CSR_AGING, 32'd0);
      write_csr(wets_pkg::CSR_THRESH, 32'd0);
      send_request(mk(wets_pkg::OP_AGE, 16'd0, 32'd0, 16'd0));
      send_request(mk(wets_pkg::OP_SEL, 16'd0, 32'd0, 16'h7777));
      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0: begin
               write_csr(wets_pkg::CSR_AGING, 32'h1_0000);
               write_csr(wets_pkg::CSR_THRESH, 32'd0);
            end
            1: begin
               write_csr(wets_pkg::CSR_AGING, 32'h0_F000);
               write_csr(wets_pkg::CSR_THRESH, 32'h100);
            end
            2: begin
               write_csr(wets_pkg::CSR_AGING, 32'h1_FFFF);
               write_csr(wets_pkg::CSR_THRESH, 32'd0);
            end
            3: begin
               write_csr(wets_pkg::CSR_AGING, 32'h0_C000);
               write_csr(wets_pkg::CSR_THRESH, 32'hFFFF_FFFF);
            end
            4: begin
               write_csr(wets_pkg::CSR_AGING, 32'h1_0000);
               write_csr(wets_pkg::CSR_THRESH, 32'h1_0000);
            end
            default: begin
               write_csr(wets_pkg::CSR_AGING, 32'h0_E000);
               write_csr(wets_pkg::CSR_THRESH, 32'h80);
            end
         endcase
         for (int n = 0; n < 200; n++) send_request(random_request());
      end
      drain();
      $display("covered %0d requests (%0d selects), %0d responses, table depth %0d",
               sent_reqs, selects_made, accepted_rsps, DEPTH);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("weighted_edge_table_selector: match");
      else
         $display("weighted_edge_table_selector: mismatch");
      $finish;
   end

endmodule
